// File: hw/rtl/state_change_trace_logger_defines.svh
// ---------------------------------------------------------------------------
// State change trace logger assertion macros
// Shared concurrent assertion forms, clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef STATE_CHANGE_TRACE_LOGGER_DEFINES_SVH
`define STATE_CHANGE_TRACE_LOGGER_DEFINES_SVH

// property checked outside reset only
`define SCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked at every edge, reset included
`define SCL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/scl_pkg.sv
// ---------------------------------------------------------------------------
// State change trace logger package
// Shared constants, record kinds, tick entry type and helper functions.
// ---------------------------------------------------------------------------
package scl_pkg;

  // defaults for the top level parameters
  localparam int unsigned LANES_DEF  = 2;
  localparam int unsigned QDEPTH_DEF = 4;

  // lanes actually carried by the lane task input
  localparam int unsigned SRC_LANES = 2;

  // reset values
  localparam logic [15:0] HB_INTERVAL_RST = 16'd100;
  localparam logic [7:0]  STATE_RST       = 8'hFF;

  // record kinds
  typedef enum logic [2:0] {
    KIND_CTRL      = 3'd0,
    KIND_SYNC      = 3'd1,
    KIND_LANE      = 3'd2,
    KIND_SENSOR    = 3'd3,
    KIND_HEARTBEAT = 3'd4
  } kind_e;

  // fields common to every record of one tick
  typedef struct packed {
    logic [31:0]        now_ms;
    logic [7:0]         ctrl;
    logic [7:0]         sync;
    logic [7:0]         sensors;
    logic [7:0]         toggled;
    logic [7:0]         active;
    logic signed [15:0] pos;
    logic signed [15:0] rate;
  } tick_t;

  // saturate a 32 bit signed rate to 16 bits signed
  function automatic logic [15:0] sat_rate(input logic [31:0] v);
    logic [15:0] r;
    if (v[31] && !(&v[30:15])) begin
      r = 16'h8000;
    end else if (!v[31] && (|v[30:15])) begin
      r = 16'h7FFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // task code of one lane, lanes not carried read as zero
  function automatic logic [7:0] lane_task(input logic [15:0] tasks, input int unsigned i);
    logic [7:0] t;
    if (i < SRC_LANES) begin
      t = 8'(tasks >> (8 * i));
    end else begin
      t = 8'd0;
    end
    return t;
  endfunction

endpackage

// File: hw/rtl/scl_front.sv
// ---------------------------------------------------------------------------
// State change trace logger front end
// Compares each tick against the last recorded values, keeps the watched
// state and queues one classified entry per tick that yields records.
// ---------------------------------------------------------------------------
module scl_front import scl_pkg::*; #(
  parameter int unsigned LANES = LANES_DEF,
  localparam int unsigned NEV  = LANES + 4,
  localparam int unsigned EW   = $bits(tick_t) + 8 * LANES + NEV
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [15:0]        hb_interval_i,
  input  logic [31:0]        now_ms_i,
  input  logic [7:0]         ctrl_state_i,
  input  logic [7:0]         sync_code_i,
  input  logic [15:0]        lane_tasks_i,
  input  logic [7:0]         sensor_mask_i,
  input  logic [7:0]         active_lane_i,
  input  logic signed [15:0] buffer_pos_i,
  input  logic signed [31:0] step_rate_i,
  output logic               q_push_o,
  output logic [EW-1:0]      q_data_o
);

  logic              baseline_q, baseline_d;
  logic [31:0]       last_time_q, last_time_d;
  logic [7:0]        prev_ctrl_q, prev_ctrl_d;
  logic [7:0]        prev_sync_q, prev_sync_d;
  logic [7:0]        prev_sens_q, prev_sens_d;
  logic [LANES-1:0][7:0] prev_lane_q, prev_lane_d;

  logic [LANES-1:0][7:0] lane_cur;
  logic [NEV-1:0]    mask;
  logic              changed;
  logic [31:0]       diff;
  logic              hb_due;
  tick_t             tick;

  // change detection and heartbeat check
  always_comb begin
    for (int unsigned i = 0; i < LANES; i++) begin
      lane_cur[i] = lane_task(lane_tasks_i, i);
    end
    mask    = '0;
    mask[0] = ctrl_state_i != prev_ctrl_q;
    mask[1] = sync_code_i != prev_sync_q;
    for (int unsigned i = 0; i < LANES; i++) begin
      mask[2 + i] = lane_cur[i] != prev_lane_q[i];
    end
    mask[LANES + 2] = sensor_mask_i != prev_sens_q;
    changed = |mask[LANES+2:0];
    diff    = now_ms_i - last_time_q;
    hb_due  = !diff[31] && (diff >= {16'd0, hb_interval_i});
    mask[LANES + 3] = !changed && hb_due;
  end

  // queued entry
  always_comb begin
    tick.now_ms  = now_ms_i;
    tick.ctrl    = ctrl_state_i;
    tick.sync    = sync_code_i;
    tick.sensors = sensor_mask_i;
    tick.toggled = sensor_mask_i ^ prev_sens_q;
    tick.active  = active_lane_i;
    tick.pos     = buffer_pos_i;
    tick.rate    = sat_rate(step_rate_i);
    q_data_o     = {tick, lane_cur, mask};
    q_push_o     = accept_i && baseline_q && (|mask);
  end

  // watched state update
  always_comb begin
    baseline_d  = baseline_q;
    last_time_d = last_time_q;
    prev_ctrl_d = prev_ctrl_q;
    prev_sync_d = prev_sync_q;
    prev_sens_d = prev_sens_q;
    prev_lane_d = prev_lane_q;
    if (accept_i) begin
      baseline_d  = 1'b1;
      prev_ctrl_d = ctrl_state_i;
      prev_sync_d = sync_code_i;
      prev_sens_d = sensor_mask_i;
      prev_lane_d = lane_cur;
      if (!baseline_q || (|mask)) begin
        last_time_d = now_ms_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q  <= 1'b0;
      last_time_q <= '0;
      prev_ctrl_q <= STATE_RST;
      prev_sync_q <= STATE_RST;
      prev_sens_q <= STATE_RST;
      prev_lane_q <= {LANES{STATE_RST}};
    end else begin
      baseline_q  <= baseline_d;
      last_time_q <= last_time_d;
      prev_ctrl_q <= prev_ctrl_d;
      prev_sync_q <= prev_sync_d;
      prev_sens_q <= prev_sens_d;
      prev_lane_q <= prev_lane_d;
    end
  end

endmodule

// File: hw/rtl/scl_queue.sv
// ---------------------------------------------------------------------------
// State change trace logger entry queue
// Small first-in first-out store of classified ticks between front and back.
// ---------------------------------------------------------------------------
module scl_queue import scl_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QDEPTH_DEF,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LAST_IDX) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LAST_IDX) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/scl_back.sv
// ---------------------------------------------------------------------------
// State change trace logger back end
// Walks the event bits of the head entry, lowest first, and loads one trace
// record per cycle into the output register while it is empty or popped.
// ---------------------------------------------------------------------------
module scl_back import scl_pkg::*; #(
  parameter int unsigned LANES = LANES_DEF,
  localparam int unsigned NEV  = LANES + 4,
  localparam int unsigned EW   = $bits(tick_t) + 8 * LANES + NEV
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [EW-1:0]      q_data_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [2:0]         record_kind_o,
  output logic [7:0]         record_lane_o,
  output logic [31:0]        record_time_o,
  output logic [7:0]         record_ctrl_o,
  output logic [7:0]         record_sync_o,
  output logic [7:0]         record_sensors_o,
  output logic signed [15:0] record_pos_o,
  output logic signed [15:0] record_rate_o,
  output logic [7:0]         record_payload_o,
  output logic               last_o
);

  tick_t                 tick;
  logic [LANES-1:0][7:0] tasks;
  logic [NEV-1:0]        mask;
  logic [NEV-1:0]        sent_q, sent_d;
  logic [NEV-1:0]        rem, sel, rest;
  logic                  load;
  logic                  out_valid_q, out_valid_d;

  kind_e                 kind_d, kind_q;
  logic [7:0]            lane_d, lane_q;
  logic [7:0]            payload_d, payload_q;
  tick_t                 tick_q;
  logic                  last_q;

  assign {tick, tasks, mask} = q_data_i;

  // pick the lowest pending event of the head entry
  always_comb begin
    rem     = mask & ~sent_q;
    sel     = rem & (~rem + 1'b1);
    rest    = rem & ~sel;
    load    = !q_empty_i && (!out_valid_q || pop_i);
    q_pop_o = load && (rest == '0);
  end

  // record decode
  always_comb begin
    kind_d    = KIND_HEARTBEAT;
    lane_d    = tick.active;
    payload_d = 8'd0;
    if (sel[0]) begin
      kind_d    = KIND_CTRL;
      payload_d = tick.ctrl;
    end
    if (sel[1]) begin
      kind_d    = KIND_SYNC;
      payload_d = tick.sync;
    end
    for (int unsigned i = 0; i < LANES; i++) begin
      if (sel[2 + i]) begin
        kind_d    = KIND_LANE;
        lane_d    = 8'(i + 1);
        payload_d = tasks[i];
      end
    end
    if (sel[LANES + 2]) begin
      kind_d    = KIND_SENSOR;
      payload_d = tick.toggled;
    end
  end

  // progress through the head entry and output valid
  always_comb begin
    sent_d      = sent_q;
    out_valid_d = out_valid_q;
    if (load) begin
      sent_d      = q_pop_o ? '0 : (sent_q | sel);
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sent_q      <= sent_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output record register
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q    <= kind_d;
      lane_q    <= lane_d;
      payload_q <= payload_d;
      tick_q    <= tick;
      last_q    <= rest == '0;
    end
  end

  assign empty_o          = !out_valid_q;
  assign record_kind_o    = kind_q;
  assign record_lane_o    = lane_q;
  assign record_time_o    = tick_q.now_ms;
  assign record_ctrl_o    = tick_q.ctrl;
  assign record_sync_o    = tick_q.sync;
  assign record_sensors_o = tick_q.sensors;
  assign record_pos_o     = tick_q.pos;
  assign record_rate_o    = tick_q.rate;
  assign record_payload_o = payload_q;
  assign last_o           = last_q;

endmodule

// File: hw/rtl/state_change_trace_logger.sv
// ---------------------------------------------------------------------------
// State change trace logger
// Emits one trace record per changed watched value, or a heartbeat record.
// ---------------------------------------------------------------------------
// A tick is taken whenever push is high and full is low. The first tick after
// reset only records the baseline. Later ticks are compared against the last
// recorded values by the front end; a tick with records is pushed as one
// entry into a QDEPTH-deep queue, a tick without records leaves nothing. The
// back end turns the head entry into records at one record per cycle while
// the output is empty or popped; a tick has 1 to LANES + 3 records, and that
// record rate is what bounds sustained throughput. The first record of a
// tick passes the queue and the output register before it shows. Records come
// in the order controller, sync, lanes from lane 1, sensors; last marks the
// final record of a tick. The heartbeat interval is written through the cfg
// port, which is always ready, and must only change while the block is idle.
`include "state_change_trace_logger_defines.svh"

module state_change_trace_logger import scl_pkg::*; #(
  parameter int unsigned LANES  = LANES_DEF,
  parameter int unsigned QDEPTH = QDEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  // tick input
  input  logic               push,
  output logic               full,
  input  logic [31:0]        now_ms_i,
  input  logic [7:0]         ctrl_state_i,
  input  logic [7:0]         sync_code_i,
  input  logic [15:0]        lane_tasks_i,
  input  logic [7:0]         sensor_mask_i,
  input  logic [7:0]         active_lane_i,
  input  logic signed [15:0] buffer_pos_i,
  input  logic signed [31:0] step_rate_i,
  // record output
  input  logic               pop,
  output logic               empty,
  output logic [2:0]         record_kind_o,
  output logic [7:0]         record_lane_o,
  output logic [31:0]        record_time_o,
  output logic [7:0]         record_ctrl_o,
  output logic [7:0]         record_sync_o,
  output logic [7:0]         record_sensors_o,
  output logic signed [15:0] record_pos_o,
  output logic signed [15:0] record_rate_o,
  output logic [7:0]         record_payload_o,
  output logic               last_o
);

  localparam int unsigned NEV = LANES + 4;
  localparam int unsigned EW  = $bits(tick_t) + 8 * LANES + NEV;

  logic [15:0]   hb_interval_q;
  logic          accept;
  logic          q_push, q_pop, q_full, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;

  // heartbeat interval register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_interval_q <= HB_INTERVAL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hb_interval_q <= cfg_data_i;
    end
  end

  // input transaction
  assign full   = q_full;
  assign accept = push && !full;

  scl_front #(
    .LANES (LANES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .hb_interval_i (hb_interval_q),
    .now_ms_i      (now_ms_i),
    .ctrl_state_i  (ctrl_state_i),
    .sync_code_i   (sync_code_i),
    .lane_tasks_i  (lane_tasks_i),
    .sensor_mask_i (sensor_mask_i),
    .active_lane_i (active_lane_i),
    .buffer_pos_i  (buffer_pos_i),
    .step_rate_i   (step_rate_i),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  scl_queue #(
    .WIDTH (EW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  scl_back #(
    .LANES (LANES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_data_i         (q_rdata),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .record_kind_o    (record_kind_o),
    .record_lane_o    (record_lane_o),
    .record_time_o    (record_time_o),
    .record_ctrl_o    (record_ctrl_o),
    .record_sync_o    (record_sync_o),
    .record_sensors_o (record_sensors_o),
    .record_pos_o     (record_pos_o),
    .record_rate_o    (record_rate_o),
    .record_payload_o (record_payload_o),
    .last_o           (last_o)
  );

  // checks
  `SCL_ASSERT(a_no_push_when_full, q_push |-> !q_full, "entry pushed into a full queue")
  `SCL_ASSERT(a_no_pop_when_empty, q_pop |-> !q_empty, "entry popped from an empty queue")
  `SCL_ASSERT(a_kind_legal, !empty |-> (record_kind_o <= KIND_HEARTBEAT), "illegal record kind")
  `SCL_ASSERT_ALWAYS(a_empty_after_reset, $past(!rst_ni) |-> empty, "record shown after reset")

endmodule
